FILE: rtl/prm_pkg.sv
// ----------------------------------------------------------------------------
// prm_pkg: shared types and constants for the pulse rate meter
// Field widths, register indexes, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package prm_pkg;

  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned AMP_BITS    = 12;
  localparam int unsigned TICK_BITS   = 8;
  localparam int unsigned SCALE_BITS  = 8;
  localparam int unsigned BEAT_BITS   = 16;
  localparam int unsigned RATE_BITS   = 16;
  localparam int unsigned PROD_BITS   = BEAT_BITS + SCALE_BITS;
  // swing and thresholds meet at the wider of the two widths
  localparam int unsigned SWING_BITS  = (SAMPLE_BITS > AMP_BITS) ? SAMPLE_BITS : AMP_BITS;
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 12;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_AMP_LOW  = 2'd0,
    REG_AMP_HIGH = 2'd1,
    REG_WINDOW   = 2'd2,
    REG_SCALE    = 2'd3
  } prm_reg_e;

  localparam logic [AMP_BITS-1:0]   AMP_LOW_RST  = AMP_BITS'(532);
  localparam logic [AMP_BITS-1:0]   AMP_HIGH_RST = AMP_BITS'(1229);
  localparam logic [TICK_BITS-1:0]  WINDOW_RST   = TICK_BITS'(10);
  localparam logic [SCALE_BITS-1:0] SCALE_RST    = SCALE_BITS'(6);

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_FULL = '1;
  localparam logic [BEAT_BITS-1:0]   BEAT_MAX    = '1;
  localparam logic [RATE_BITS-1:0]   RATE_MAX    = '1;

  typedef struct packed {
    logic [AMP_BITS-1:0]   amp_low;
    logic [AMP_BITS-1:0]   amp_high;
    logic [TICK_BITS-1:0]  window_ticks;
    logic [SCALE_BITS-1:0] rate_scale;
  } prm_cfg_t;

endpackage

FILE: rtl/prm_if.sv
// ----------------------------------------------------------------------------
// prm_in_if / prm_out_if: valid/ready channels of the pulse rate meter
// Input carries operation and sample, output carries the rate.
// ----------------------------------------------------------------------------
interface prm_in_if import prm_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   operation;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output operation, output sample, input ready);
  modport sink   (input valid, input operation, input sample, output ready);
endinterface

interface prm_out_if import prm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [RATE_BITS-1:0] beats_per_minute;

  modport source (output valid, output beats_per_minute, input ready);
  modport sink   (input valid, input beats_per_minute, output ready);
endinterface

FILE: rtl/prm_beat_detect.sv
// ----------------------------------------------------------------------------
// prm_beat_detect: peak/trough tracking and beat counting
// Counts a beat on a falling sample whose swing lies in the amplitude band.
// ----------------------------------------------------------------------------
module prm_beat_detect import prm_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   sample_en_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic                   clear_i,
  input  prm_cfg_t               cfg_i,
  output logic [BEAT_BITS-1:0]   beat_count_o
);

  logic [SAMPLE_BITS-1:0] prev_q, prev_d;
  logic [SAMPLE_BITS-1:0] peak_q, peak_d;
  logic [SAMPLE_BITS-1:0] trough_q, trough_d;
  logic [BEAT_BITS-1:0]   beat_q, beat_d;
  logic [SAMPLE_BITS-1:0] swing;
  logic                   in_band;

  assign swing   = peak_q - trough_q;
  // zero-extend swing and thresholds to a common width before compare
  assign in_band = (peak_q >= trough_q) &&
                   (SWING_BITS'(swing) >= SWING_BITS'(cfg_i.amp_low)) &&
                   (SWING_BITS'(swing) <= SWING_BITS'(cfg_i.amp_high));

  always_comb begin
    prev_d   = prev_q;
    peak_d   = peak_q;
    trough_d = trough_q;
    beat_d   = beat_q;
    if (clear_i) begin
      beat_d = '0;
    end else if (sample_en_i) begin
      prev_d = sample_i;
      if (sample_i > prev_q) begin
        if (sample_i > peak_q)   peak_d   = sample_i;
        if (sample_i < trough_q) trough_d = sample_i;
      end else if (sample_i < prev_q && in_band) begin
        peak_d   = '0;
        trough_d = SAMPLE_FULL;
        if (beat_q != BEAT_MAX) beat_d = beat_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= '0;
      peak_q   <= '0;
      trough_q <= SAMPLE_FULL;
      beat_q   <= '0;
    end else begin
      prev_q   <= prev_d;
      peak_q   <= peak_d;
      trough_q <= trough_d;
      beat_q   <= beat_d;
    end
  end

  assign beat_count_o = beat_q;

endmodule

FILE: rtl/prm_rate_window.sv
// ----------------------------------------------------------------------------
// prm_rate_window: tick counting and rate computation
// Flags the tick that ends a window and forms beats times scale, saturated.
// ----------------------------------------------------------------------------
module prm_rate_window import prm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 tick_en_i,
  input  prm_cfg_t             cfg_i,
  input  logic [BEAT_BITS-1:0] beat_count_i,
  output logic                 done_o,
  output logic [RATE_BITS-1:0] rate_o
);

  logic [TICK_BITS-1:0] tick_q, tick_d;
  logic [TICK_BITS-1:0] tick_inc;
  logic [TICK_BITS-1:0] limit;
  logic [PROD_BITS-1:0] prod;

  // a window of zero behaves as one
  assign limit    = (cfg_i.window_ticks == '0) ? TICK_BITS'(1) : cfg_i.window_ticks;
  assign tick_inc = tick_q + 1'b1;
  assign done_o   = tick_en_i && ((tick_inc == '0) || (tick_inc >= limit));

  always_comb begin
    tick_d = tick_q;
    if (done_o)         tick_d = '0;
    else if (tick_en_i) tick_d = tick_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tick_q <= '0;
    else         tick_q <= tick_d;
  end

  assign prod   = PROD_BITS'(beat_count_i) * PROD_BITS'(cfg_i.rate_scale);
  assign rate_o = (prod[PROD_BITS-1:RATE_BITS] != '0) ? RATE_MAX : prod[RATE_BITS-1:0];

endmodule

FILE: rtl/pulse_rate_meter_unit.sv
// ----------------------------------------------------------------------------
// pulse_rate_meter_unit: pulse sensor beat counter and rate meter
// Input register, one pass of update logic, output register.
// ----------------------------------------------------------------------------
// Timing: a window-ending tick is held in the input register; the rate register
//   loads when that tick advances, and the rate waits there until out_o.ready takes it.
// Throughput: 1 item per cycle while the output slot is free or being emptied; the
//   single update pass between input and output registers sets it, and an untaken rate stalls input.
// Reset: asynchronous, active low; clears state, counters and valid flags,
//   and loads the register defaults. No clearing pass.
// ----------------------------------------------------------------------------
module pulse_rate_meter_unit import prm_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  prm_in_if.sink                   in_i,
  prm_out_if.source                out_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  // configuration registers
  prm_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.amp_low      <= AMP_LOW_RST;
      cfg_q.amp_high     <= AMP_HIGH_RST;
      cfg_q.window_ticks <= WINDOW_RST;
      cfg_q.rate_scale   <= SCALE_RST;
    end else if (cfg_we_i) begin
      case (prm_reg_e'(cfg_index_i))
        REG_AMP_LOW:  cfg_q.amp_low      <= cfg_data_i[AMP_BITS-1:0];
        REG_AMP_HIGH: cfg_q.amp_high     <= cfg_data_i[AMP_BITS-1:0];
        REG_WINDOW:   cfg_q.window_ticks <= cfg_data_i[TICK_BITS-1:0];
        REG_SCALE:    cfg_q.rate_scale   <= cfg_data_i[SCALE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // input register stage
  logic                   in_valid_q;
  logic                   in_op_q;
  logic [SAMPLE_BITS-1:0] in_sample_q;
  logic                   advance;
  logic                   out_valid_q;
  logic [RATE_BITS-1:0]   bpm_q;

  // stage moves on whenever the output slot is free or being emptied
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_op_q     <= in_i.operation;
      in_sample_q <= in_i.sample;
    end
  end

  // update logic
  logic                 sample_en;
  logic                 tick_en;
  logic                 window_done;
  logic [BEAT_BITS-1:0] beat_count;
  logic [RATE_BITS-1:0] rate;

  assign sample_en = advance && !in_op_q;
  assign tick_en   = advance && in_op_q;

  prm_beat_detect u_beat (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_en_i (sample_en),
    .sample_i    (in_sample_q),
    .clear_i     (window_done),
    .cfg_i       (cfg_q),
    .beat_count_o(beat_count)
  );

  prm_rate_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_en_i   (tick_en),
    .cfg_i       (cfg_q),
    .beat_count_i(beat_count),
    .done_o      (window_done),
    .rate_o      (rate)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (window_done) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (window_done) bpm_q <= rate;
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.beats_per_minute = bpm_q;

  // checks
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled with empty output");

  a_result_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_op_q && advance))
    else $error("result without a window-ending tick");

  a_beats_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    window_done |=> (beat_count == '0))
    else $error("beat count not cleared at window end");

endmodule
